@@ design/qacct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qacct_pkg
// shared types and constants of the two-level byte quota accountant
// ----------------------------------------------------------------------------
package qacct_pkg;

    localparam int NUM_ACCOUNTS_DEF = 16;
    localparam int BYTE_WIDTH_DEF   = 32;

    localparam int FUNC_W   = 2;
    localparam int OPID_W   = 4;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [FUNC_W-1:0] FN_OPEN    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_SHARED_LIMIT = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOT_OPEN  = 3'd2,
        ST_SINGLE    = 3'd3,
        ST_OP        = 3'd4,
        ST_SHARED    = 3'd5,
        ST_UNDERFLOW = 3'd6,
        ST_BUSY      = 3'd7
    } qacct_status_t;

    typedef struct packed {
        logic load;
        logic check;
        logic commit;
    } qacct_cmd_t;

endpackage : qacct_pkg
`default_nettype wire

@@ design/qacct_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qacct_ctrl
// request sequencer: accept, check, commit into the output register
// ----------------------------------------------------------------------------
module qacct_ctrl
    import qacct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    output qacct_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.check  = (state_reg == S_CHECK);
        cmd.commit = (state_reg == S_UPDATE) && out_free;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : qacct_ctrl
`default_nettype wire

@@ design/qacct_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qacct_dp
// account memory, pool counters, limit checks and result register
// ----------------------------------------------------------------------------
module qacct_dp
    import qacct_pkg::*;
#(
    parameter int NUM_ACCOUNTS = NUM_ACCOUNTS_DEF,
    parameter int BYTE_WIDTH   = BYTE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire qacct_cmd_t            cmd,
    input  wire logic [BYTE_WIDTH-1:0] shared_limit,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [OPID_W-1:0]     op_id,
    input  wire logic [FIELD_W-1:0]    amount,
    input  wire logic [FIELD_W-1:0]    new_op_limit,
    input  wire logic [FIELD_W-1:0]    new_single_limit,
    output logic [STATUS_W-1:0]        status,
    output logic                       granted,
    output logic [FIELD_W-1:0]         op_current,
    output logic [FIELD_W-1:0]         op_peak,
    output logic [FIELD_W-1:0]         pool_current,
    output logic [FIELD_W-1:0]         pool_peak
);

    localparam int IDX_W = (NUM_ACCOUNTS > 1) ? $clog2(NUM_ACCOUNTS) : 1;
    localparam int BW    = BYTE_WIDTH;

    logic [BW-1:0] cap_mem    [NUM_ACCOUNTS];
    logic [BW-1:0] single_mem [NUM_ACCOUNTS];
    logic [BW-1:0] used_mem   [NUM_ACCOUNTS];
    logic [BW-1:0] high_mem   [NUM_ACCOUNTS];

    logic [NUM_ACCOUNTS-1:0] open_reg;
    logic [BW-1:0]           pool_used_reg;
    logic [BW-1:0]           pool_high_reg;

    logic [FUNC_W-1:0] req_func_reg;
    logic [IDX_W-1:0]  req_idx_reg;
    logic              req_valid_id_reg;
    logic [BW-1:0]     req_amt_reg;
    logic [BW-1:0]     req_lim_reg;
    logic [BW-1:0]     req_single_reg;

    logic [BW-1:0] rd_cap_reg;
    logic [BW-1:0] rd_single_reg;
    logic [BW-1:0] rd_used_reg;
    logic [BW-1:0] rd_high_reg;

    qacct_status_t check_status_reg;
    qacct_status_t check_status_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic                out_granted_reg;
    logic [FIELD_W-1:0]  out_op_cur_reg;
    logic [FIELD_W-1:0]  out_op_peak_reg;
    logic [FIELD_W-1:0]  out_pool_cur_reg;
    logic [FIELD_W-1:0]  out_pool_peak_reg;

    logic [IDX_W-1:0] in_idx;
    logic             in_valid_id;
    logic             rd_open;
    logic [BW-1:0]    cur_used;
    logic [BW-1:0]    cur_high;
    logic [BW-1:0]    op_headroom;
    logic [BW-1:0]    pool_headroom;
    logic             ok;
    logic [BW-1:0]    used_sum;
    logic [BW-1:0]    pool_sum;
    logic [BW-1:0]    used_next;
    logic [BW-1:0]    high_next;
    logic [BW-1:0]    pool_used_next;
    logic [BW-1:0]    pool_high_next;
    logic             wr_usage;
    logic             wr_caps;

    assign in_idx      = IDX_W'(op_id);
    assign in_valid_id = ({{(32-OPID_W){1'b0}}, op_id} < 32'(NUM_ACCOUNTS));

    // unopened entries read as cleared usage
    assign rd_open  = req_valid_id_reg && open_reg[req_idx_reg];
    assign cur_used = rd_open ? rd_used_reg : '0;
    assign cur_high = rd_open ? rd_high_reg : '0;

    assign op_headroom   = (cur_used >= rd_cap_reg) ? '0 : (rd_cap_reg - cur_used);
    assign pool_headroom = (pool_used_reg >= shared_limit) ? '0
                                                           : (shared_limit - pool_used_reg);

    always_comb
    begin
        priority if (req_func_reg != FN_OPEN && req_func_reg != FN_RESERVE &&
                     req_func_reg != FN_RELEASE)
        begin
            check_status_next = ST_INVALID;
        end
        else if (!req_valid_id_reg)
        begin
            check_status_next = ST_NOT_OPEN;
        end
        else if (req_func_reg == FN_OPEN)
        begin
            priority if (req_lim_reg == '0 || req_lim_reg > shared_limit ||
                         req_single_reg == '0 || req_single_reg > req_lim_reg)
            begin
                check_status_next = ST_INVALID;
            end
            else if (rd_open && cur_used != '0)
            begin
                check_status_next = ST_BUSY;
            end
            else
            begin
                check_status_next = ST_OK;
            end
        end
        else if (!rd_open)
        begin
            check_status_next = ST_NOT_OPEN;
        end
        else if (req_func_reg == FN_RESERVE)
        begin
            priority if (req_amt_reg > rd_single_reg)
            begin
                check_status_next = ST_SINGLE;
            end
            else if (req_amt_reg > op_headroom)
            begin
                check_status_next = ST_OP;
            end
            else if (req_amt_reg > pool_headroom)
            begin
                check_status_next = ST_SHARED;
            end
            else
            begin
                check_status_next = ST_OK;
            end
        end
        else
        begin
            if (req_amt_reg > cur_used || req_amt_reg > pool_used_reg)
            begin
                check_status_next = ST_UNDERFLOW;
            end
            else
            begin
                check_status_next = ST_OK;
            end
        end
    end

    assign ok       = (check_status_reg == ST_OK);
    assign used_sum = cur_used + req_amt_reg;
    assign pool_sum = pool_used_reg + req_amt_reg;

    always_comb
    begin
        used_next      = cur_used;
        high_next      = cur_high;
        pool_used_next = pool_used_reg;
        pool_high_next = pool_high_reg;
        wr_usage       = 1'b0;
        wr_caps        = 1'b0;
        if (ok)
        begin
            unique case (req_func_reg)
                FN_OPEN:
                begin
                    used_next = '0;
                    high_next = '0;
                    wr_usage  = 1'b1;
                    wr_caps   = 1'b1;
                end
                FN_RESERVE:
                begin
                    used_next      = used_sum;
                    high_next      = (used_sum > cur_high) ? used_sum : cur_high;
                    pool_used_next = pool_sum;
                    pool_high_next = (pool_sum > pool_high_reg) ? pool_sum : pool_high_reg;
                    wr_usage       = 1'b1;
                end
                FN_RELEASE:
                begin
                    used_next      = cur_used - req_amt_reg;
                    pool_used_next = pool_used_reg - req_amt_reg;
                    wr_usage       = 1'b1;
                end
                default:
                begin
                    wr_usage = 1'b0;
                end
            endcase
        end
    end

    // request capture and account read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_func_reg     <= func;
            req_idx_reg      <= in_idx;
            req_valid_id_reg <= in_valid_id;
            req_amt_reg      <= BW'(amount);
            req_lim_reg      <= BW'(new_op_limit);
            req_single_reg   <= BW'(new_single_limit);
            rd_cap_reg       <= cap_mem[in_idx];
            rd_single_reg    <= single_mem[in_idx];
            rd_used_reg      <= used_mem[in_idx];
            rd_high_reg      <= high_mem[in_idx];
        end
        if (cmd.check)
        begin
            check_status_reg <= check_status_next;
        end
    end

    // account write
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_usage)
        begin
            used_mem[req_idx_reg] <= used_next;
            high_mem[req_idx_reg] <= high_next;
        end
        if (cmd.commit && wr_caps)
        begin
            cap_mem[req_idx_reg]    <= req_lim_reg;
            single_mem[req_idx_reg] <= req_single_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            pool_used_reg <= '0;
            pool_high_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_caps)
            begin
                open_reg[req_idx_reg] <= 1'b1;
            end
            pool_used_reg <= pool_used_next;
            pool_high_reg <= pool_high_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg    <= check_status_reg;
            out_granted_reg   <= ok;
            out_op_cur_reg    <= FIELD_W'(used_next);
            out_op_peak_reg   <= FIELD_W'(high_next);
            out_pool_cur_reg  <= FIELD_W'(pool_used_next);
            out_pool_peak_reg <= FIELD_W'(pool_high_next);
        end
    end

    assign status       = out_status_reg;
    assign granted      = out_granted_reg;
    assign op_current   = out_op_cur_reg;
    assign op_peak      = out_op_peak_reg;
    assign pool_current = out_pool_cur_reg;
    assign pool_peak    = out_pool_peak_reg;

endmodule : qacct_dp
`default_nettype wire

@@ design/two_level_byte_quota_accountant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_byte_quota_accountant
// byte budget accountant with a shared pool and a table of operation accounts
// a request is captured with its account read, checked, then committed
// into the result register; a new request waits until that commit is done
// a new request is accepted while the previous result waits at the output
// reset: all accounts closed, pool usage and peak zero, shared_limit all ones
// ----------------------------------------------------------------------------
module two_level_byte_quota_accountant
    import qacct_pkg::*;
#(
    parameter int NUM_ACCOUNTS = NUM_ACCOUNTS_DEF,
    parameter int BYTE_WIDTH   = BYTE_WIDTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [OPID_W-1:0]   op_id,
    input  wire logic [FIELD_W-1:0]  amount,
    input  wire logic [FIELD_W-1:0]  new_op_limit,
    input  wire logic [FIELD_W-1:0]  new_single_limit,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic                     granted,
    output logic [FIELD_W-1:0]       op_current,
    output logic [FIELD_W-1:0]       op_peak,
    output logic [FIELD_W-1:0]       pool_current,
    output logic [FIELD_W-1:0]       pool_peak,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [BYTE_WIDTH-1:0] shared_limit_reg;
    logic                  cfg_wr;
    qacct_cmd_t            cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == CFG_IDX_SHARED_LIMIT);
    assign prdata = (paddr[2] == CFG_IDX_SHARED_LIMIT) ? PDATA_W'(shared_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_limit_reg <= BYTE_WIDTH'(32'hFFFF_FFFF);
        end
        else if (cfg_wr)
        begin
            shared_limit_reg <= BYTE_WIDTH'(pwdata);
        end
    end

    qacct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    qacct_dp #(
        .NUM_ACCOUNTS (NUM_ACCOUNTS),
        .BYTE_WIDTH   (BYTE_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .shared_limit     (shared_limit_reg),
        .func             (func),
        .op_id            (op_id),
        .amount           (amount),
        .new_op_limit     (new_op_limit),
        .new_single_limit (new_single_limit),
        .status           (status),
        .granted          (granted),
        .op_current       (op_current),
        .op_peak          (op_peak),
        .pool_current     (pool_current),
        .pool_peak        (pool_peak)
    );

endmodule : two_level_byte_quota_accountant
`default_nettype wire
